>>> sv/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;

    localparam int SLOT_W    = 16;   // period, timer and pending width
    localparam int CMD_W     = 3;
    localparam int TIDX_W    = 8;    // width of the task_index field
    localparam int DLY_W     = 8;
    localparam int DSLOT_W   = 4;    // width of dispatch_slot

    localparam logic [SLOT_W-1:0] PEND_SAT = {SLOT_W{1'b1}};

    // Request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_SETUP = 3'd1,
        CMD_TRIG  = 3'd2,
        CMD_DELAY = 3'd3,
        CMD_DISP  = 3'd4
    } cmd_t;

    // Operations of the shared slot unit
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_SETUP,
        OP_TRIG,
        OP_DELAY,
        OP_CLEAR
    } op_t;

    // Operands handed to the slot unit for one slot
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] period;
        logic [SLOT_W-1:0] timer;
        logic [SLOT_W-1:0] pending;
        logic [SLOT_W-1:0] arg_period;
        logic [SLOT_W-1:0] arg_start;
        logic [DLY_W-1:0]  arg_delay;
    } unit_req_t;

    // Write-back and status from the slot unit
    typedef struct packed {
        logic              wr_period;
        logic              wr_timer;
        logic              wr_pending;
        logic              limit_hit;
        logic              found;
        logic [SLOT_W-1:0] period;
        logic [SLOT_W-1:0] timer;
        logic [SLOT_W-1:0] pending;
    } unit_rsp_t;

endpackage
`default_nettype wire

>>> sv/periodic_task_tick_scheduler_top.sv
// Top level of the periodic task tick scheduler: slot state and sequencer.
//
// Usage: a request (cmd, task_index, period, start_time, delay) is taken at
// a rising edge where start is high and busy is low. Exactly one result
// (overrun, dispatch_valid, dispatch_slot) follows, shown for one cycle with
// done high; the receiver cannot hold it off. Result fields are zero outside
// the done cycle and zero for commands that do not produce them.
// Sequencing: a tick or dispatch walks the slots one per cycle through the
// shared slot unit while busy is high (a tick stops at the first slot that
// reaches the pending limit, a dispatch at the first pending slot); setup,
// trigger, delay and unused codes are handled in the ST_ONE state.
// done rises in the cycle after the last busy cycle, in which busy is low
// again and the next request may already be taken.
// Reset clears every slot's period, timer and pending count (all slots
// aperiodic and idle) and drops busy and done.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_tick_scheduler_top #(
    parameter int TASKS         = 8,
    parameter int PENDING_LIMIT = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ptts_pkg::CMD_W-1:0]     cmd,
    input  wire logic [ptts_pkg::TIDX_W-1:0]    task_index,
    input  wire logic [ptts_pkg::SLOT_W-1:0]    period,
    input  wire logic [ptts_pkg::SLOT_W-1:0]    start_time,
    input  wire logic [ptts_pkg::DLY_W-1:0]     delay,
    output logic                                done,
    output logic                                overrun,
    output logic                                dispatch_valid,
    output logic [ptts_pkg::DSLOT_W-1:0]        dispatch_slot
);
    import ptts_pkg::*;

    localparam int            IW   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [IW-1:0] LAST = IW'(TASKS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DISP,
        ST_ONE
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     idx_reg;
    logic              ok_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [SLOT_W-1:0] arg_period_reg;
    logic [SLOT_W-1:0] arg_start_reg;
    logic [DLY_W-1:0]  arg_delay_reg;
    logic              done_reg;
    logic              overrun_reg;
    logic              dvalid_reg;
    logic [DSLOT_W-1:0] dslot_reg;

    logic [SLOT_W-1:0] slot_period_reg  [TASKS];
    logic [SLOT_W-1:0] slot_timer_reg   [TASKS];
    logic [SLOT_W-1:0] slot_pending_reg [TASKS];

    logic      accept;
    logic      wr_en;
    op_t       op;
    unit_req_t req;
    unit_rsp_t rsp;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Operation for the current sequencer step
    always_comb
    begin
        op = OP_NONE;
        case (state_reg)
            ST_TICK: op = OP_TICK;
            ST_DISP: op = OP_CLEAR;
            ST_ONE:
            begin
                case (cmd_reg)
                    CMD_SETUP: op = OP_SETUP;
                    CMD_TRIG:  op = OP_TRIG;
                    CMD_DELAY: op = OP_DELAY;
                    default:   op = OP_NONE;
                endcase
            end
            default: op = OP_NONE;
        endcase
    end

    assign wr_en = (state_reg == ST_TICK) || (state_reg == ST_DISP)
                || ((state_reg == ST_ONE) && ok_reg);

    // Slot read for the shared unit
    always_comb
    begin
        req            = '0;
        req.op         = op;
        req.period     = slot_period_reg[idx_reg];
        req.timer      = slot_timer_reg[idx_reg];
        req.pending    = slot_pending_reg[idx_reg];
        req.arg_period = arg_period_reg;
        req.arg_start  = arg_start_reg;
        req.arg_delay  = arg_delay_reg;
    end

    ptts_slot_unit #(
        .PENDING_LIMIT (PENDING_LIMIT)
    ) u_unit (
        .req (req),
        .rsp (rsp)
    );

    // Slot state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                slot_period_reg[i]  <= '0;
                slot_timer_reg[i]   <= '0;
                slot_pending_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (rsp.wr_period)
                slot_period_reg[idx_reg] <= rsp.period;
            if (rsp.wr_timer)
                slot_timer_reg[idx_reg] <= rsp.timer;
            if (rsp.wr_pending)
                slot_pending_reg[idx_reg] <= rsp.pending;
        end
    end

    // Request latch, sequencer and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            ok_reg         <= 1'b0;
            cmd_reg        <= '0;
            arg_period_reg <= '0;
            arg_start_reg  <= '0;
            arg_delay_reg  <= '0;
            done_reg       <= 1'b0;
            overrun_reg    <= 1'b0;
            dvalid_reg     <= 1'b0;
            dslot_reg      <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            overrun_reg <= 1'b0;
            dvalid_reg  <= 1'b0;
            dslot_reg   <= '0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= cmd;
                        arg_period_reg <= period;
                        arg_start_reg  <= start_time;
                        arg_delay_reg  <= delay;
                        ok_reg         <= (task_index < TIDX_W'(TASKS));
                        case (cmd)
                            CMD_TICK:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_TICK;
                            end
                            CMD_DISP:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_DISP;
                            end
                            default:
                            begin
                                idx_reg   <= task_index[IW-1:0];
                                state_reg <= ST_ONE;
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (rsp.limit_hit || (idx_reg == LAST))
                    begin
                        done_reg    <= 1'b1;
                        overrun_reg <= rsp.limit_hit;
                        state_reg   <= ST_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DISP:
                begin
                    if (rsp.found || (idx_reg == LAST))
                    begin
                        done_reg   <= 1'b1;
                        dvalid_reg <= rsp.found;
                        dslot_reg  <= rsp.found ? DSLOT_W'(idx_reg) : '0;
                        state_reg  <= ST_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_ONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done           = done_reg;
    assign overrun        = overrun_reg;
    assign dispatch_valid = dvalid_reg;
    assign dispatch_slot  = dslot_reg;

endmodule
`default_nettype wire

>>> sv/ptts_slot_unit.sv
// Shared slot update unit: setup, timer advance, pending bump, delay and dispatch clear.
`timescale 1ns / 1ps
`default_nettype none
module ptts_slot_unit #(
    parameter int PENDING_LIMIT = 10
) (
    input  ptts_pkg::unit_req_t req,
    output ptts_pkg::unit_rsp_t rsp
);
    import ptts_pkg::*;

    localparam logic [SLOT_W:0] LIMIT_X = (SLOT_W+1)'(PENDING_LIMIT);

    logic [SLOT_W-1:0] timer_inc;
    logic              fire;
    logic [SLOT_W-1:0] pend_sat;
    logic [SLOT_W:0]   pend_plus;
    logic [SLOT_W-1:0] pend_capped;
    logic [SLOT_W-1:0] delay_x;

    // Arithmetic shared between the operations
    assign timer_inc   = req.timer + 1'b1;
    assign fire        = (timer_inc >= req.period);
    assign pend_sat    = (req.pending == PEND_SAT) ? req.pending : req.pending + 1'b1;
    assign pend_plus   = {1'b0, req.pending} + 1'b1;
    assign pend_capped = (pend_plus >= LIMIT_X) ? LIMIT_X[SLOT_W-1:0]
                                                : pend_plus[SLOT_W-1:0];
    assign delay_x     = SLOT_W'(req.arg_delay);

    // Operation select
    always_comb
    begin
        rsp            = '0;
        rsp.period     = req.period;
        rsp.timer      = req.timer;
        rsp.pending    = req.pending;
        case (req.op)
            OP_TICK:
            begin
                if (req.period != '0)
                begin
                    rsp.wr_timer = 1'b1;
                    rsp.timer    = fire ? '0 : timer_inc;
                    if (fire)
                    begin
                        rsp.wr_pending = 1'b1;
                        rsp.pending    = pend_sat;
                        rsp.limit_hit  = ((SLOT_W+1)'(pend_sat) >= LIMIT_X);
                    end
                end
            end
            OP_SETUP:
            begin
                rsp.wr_period = 1'b1;
                rsp.wr_timer  = 1'b1;
                rsp.period    = req.arg_period;
                rsp.timer     = req.arg_start;
            end
            OP_TRIG:
            begin
                if (req.period == '0)
                begin
                    rsp.wr_pending = 1'b1;
                    rsp.pending    = pend_capped;
                end
            end
            OP_DELAY:
            begin
                if (req.arg_delay == '0)
                begin
                    rsp.wr_pending = 1'b1;
                    rsp.pending    = pend_capped;
                end
                else if (delay_x <= req.period)
                begin
                    rsp.wr_timer = 1'b1;
                    rsp.timer    = req.period - delay_x;
                end
            end
            OP_CLEAR:
            begin
                if (req.pending != '0)
                begin
                    rsp.found      = 1'b1;
                    rsp.wr_pending = 1'b1;
                    rsp.pending    = '0;
                end
            end
            default:
            begin
                rsp.wr_period = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/ptts_checker.sv
// Port-level checks for the periodic task tick scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptts_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       overrun,
    input wire logic       dispatch_valid,
    input wire logic [3:0] dispatch_slot
);

    // An accepted request always occupies the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Busy only rises after an accepted request
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && !$past(busy)))
        else $error("busy rose without a request");

    // A result strobe ends the busy period and never repeats back to back
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)) ##1 !done)
        else $error("result strobe outside end of request");

    // Result fields are quiet outside the strobe, and tick and dispatch never mix
    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!done |-> (!overrun && !dispatch_valid && dispatch_slot == 4'd0))
        && !(overrun && dispatch_valid))
        else $error("result fields active outside a result");

endmodule

bind periodic_task_tick_scheduler_top ptts_checker u_ptts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .overrun        (overrun),
    .dispatch_valid (dispatch_valid),
    .dispatch_slot  (dispatch_slot)
);
`default_nettype wire

>>> tb/sv/tb_periodic_task_tick_scheduler_top.sv
// Testbench for the periodic task tick scheduler: directed and random requests.
`timescale 1ns / 1ps
module tb_periodic_task_tick_scheduler_top;
    import ptts_pkg::*;

    localparam int SLOTS      = 8;
    localparam int LIMIT      = 10;
    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 10;
    localparam int MAX_GAP    = 16;
    // No request or result for this many cycles means the block is hung
    localparam int STALL_LIMIT = 400;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_PRINTED = 50;
    // Ticks on a period-1 slot, enough to push its count well past the limit
    localparam int OVER_TICKS = 40;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic               overrun;
        logic               dispatch_valid;
        logic [DSLOT_W-1:0] dispatch_slot;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0]   cmd;
    logic [TIDX_W-1:0]  task_index;
    logic [SLOT_W-1:0]  period;
    logic [SLOT_W-1:0]  start_time;
    logic [DLY_W-1:0]   delay;
    logic               done;
    logic               overrun;
    logic               dispatch_valid;
    logic [DSLOT_W-1:0] dispatch_slot;

    // Predicted slot state
    logic [SLOT_W-1:0] exp_period [SLOTS];
    logic [SLOT_W-1:0] exp_timer  [SLOTS];
    logic [SLOT_W-1:0] exp_count  [SLOTS];

    outcome_t outcome_q[$];
    int       err_count = 0;
    int       stall_cycles;
    logic     burst_mode = 1'b0;

    periodic_task_tick_scheduler_top #(
        .TASKS         (SLOTS),
        .PENDING_LIMIT (LIMIT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .task_index     (task_index),
        .period         (period),
        .start_time     (start_time),
        .delay          (delay),
        .done           (done),
        .overrun        (overrun),
        .dispatch_valid (dispatch_valid),
        .dispatch_slot  (dispatch_slot)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        // keep the log short; every mismatch still counts
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // One more activation, held at the limit
    function automatic void raise_count(input int s);
        int nxt;
        nxt = int'(exp_count[s]) + 1;
        if (nxt >= LIMIT)
            nxt = LIMIT;
        exp_count[s] = nxt[SLOT_W-1:0];
    endfunction

    // Applies one request to the predicted slot state and returns its result
    function automatic outcome_t step_schedule(
        input logic [CMD_W-1:0]  c,
        input logic [TIDX_W-1:0] idx,
        input logic [SLOT_W-1:0] per,
        input logic [SLOT_W-1:0] st,
        input logic [DLY_W-1:0]  dly
    );
        outcome_t o;
        logic     ok;
        logic     hit;
        int       s;
        int       k;
        o   = '0;
        ok  = (idx < SLOTS);
        s   = ok ? int'(idx) : 0;
        hit = 1'b0;
        case (c)
            CMD_TICK:
            begin
                // walk slots in order, stop after the first one at the limit
                for (k = 0; k < SLOTS; k++)
                begin
                    if (!hit && exp_period[k] != '0)
                    begin
                        exp_timer[k] = exp_timer[k] + 1'b1;
                        if (exp_timer[k] >= exp_period[k])
                        begin
                            exp_timer[k] = '0;
                            if (exp_count[k] != PEND_SAT)
                                exp_count[k] = exp_count[k] + 1'b1;
                            if (exp_count[k] >= LIMIT)
                                hit = 1'b1;
                        end
                    end
                end
                o.overrun = hit;
            end
            CMD_SETUP:
            begin
                if (ok)
                begin
                    exp_period[s] = per;
                    exp_timer[s]  = st;
                end
            end
            CMD_TRIG:
            begin
                if (ok && exp_period[s] == '0)
                    raise_count(s);
            end
            CMD_DELAY:
            begin
                if (ok)
                begin
                    if (dly != '0)
                    begin
                        if (SLOT_W'(dly) <= exp_period[s])
                            exp_timer[s] = exp_period[s] - SLOT_W'(dly);
                    end
                    else
                        raise_count(s);
                end
            end
            CMD_DISP:
            begin
                for (k = 0; k < SLOTS; k++)
                begin
                    if (!o.dispatch_valid && exp_count[k] != '0)
                    begin
                        exp_count[k]    = '0;
                        o.dispatch_valid = 1'b1;
                        o.dispatch_slot  = k[DSLOT_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Issue one request after a random gap, or none in burst mode; predict it once accepted
    task automatic send_request(
        input logic [CMD_W-1:0]  c,
        input logic [TIDX_W-1:0] idx,
        input logic [SLOT_W-1:0] per,
        input logic [SLOT_W-1:0] st,
        input logic [DLY_W-1:0]  dly
    );
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= c;
        task_index <= idx;
        period     <= per;
        start_time <= st;
        delay      <= dly;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome_q.push_back(step_schedule(c, idx, per, st, dly));
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
                flag_error("result with no request outstanding");
            else
            begin
                want = outcome_q.pop_front();
                if (overrun !== want.overrun)
                    flag_error($sformatf("overrun %b, predicted %b",
                                         overrun, want.overrun));
                if (dispatch_valid !== want.dispatch_valid)
                    flag_error($sformatf("dispatch_valid %b, predicted %b",
                                         dispatch_valid, want.dispatch_valid));
                if (dispatch_slot !== want.dispatch_slot)
                    flag_error($sformatf("dispatch_slot %0d, predicted %0d",
                                         dispatch_slot, want.dispatch_slot));
            end
        end
    end

    // Watchdog on cycles with no request taken and no result shown
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Dispatch before anything is pending
    task automatic test_idle_dispatch();
        send_request(CMD_DISP, 8'd0, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    // Periodic slots: firing, timer wrap, timer starting above its period
    task automatic test_setup_tick();
        send_request(CMD_SETUP, 8'd0, 16'd3, 16'd0, 8'd0);
        send_request(CMD_SETUP, 8'd2, 16'd2, 16'd5, 8'd0);
        send_request(CMD_SETUP, 8'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_SETUP, 8'd255, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_SETUP, 8'd8, 16'd1, 16'd0, 8'd0);
        repeat (3) send_request(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        repeat (3) send_request(CMD_DISP, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    // Aperiodic triggers up to the cap, periodic and out-of-range triggers
    task automatic test_trigger();
        repeat (11) send_request(CMD_TRIG, 8'd1, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TRIG, 8'd0, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TRIG, 8'd8, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TRIG, 8'd255, 16'd0, 16'd0, 8'd0);
        send_request(CMD_DISP, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    // Delay: zero, equal to, below and above the period, aperiodic, out of range
    task automatic test_delay();
        send_request(CMD_DELAY, 8'd3, 16'd0, 16'd0, 8'd0);
        send_request(CMD_DELAY, 8'd0, 16'd0, 16'd0, 8'd3);
        send_request(CMD_DELAY, 8'd0, 16'd0, 16'd0, 8'd4);
        send_request(CMD_DELAY, 8'd7, 16'd0, 16'd0, 8'hFF);
        send_request(CMD_DELAY, 8'd2, 16'd0, 16'd0, 8'd1);
        send_request(CMD_DELAY, 8'd4, 16'd0, 16'd0, 8'd5);
        send_request(CMD_DELAY, 8'd255, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        repeat (2) send_request(CMD_DISP, 8'd0, 16'd0, 16'd0, 8'd0);
    endtask

    // Codes with no meaning
    task automatic test_unused_codes();
        for (int k = int'(CMD_RSVD_LO); k <= int'(CMD_RSVD_HI); k++)
            send_request(CMD_W'(k), 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
    endtask

    // A period-1 slot ticked well past the limit, then brought back to the cap
    task automatic test_pending_over_limit();
        burst_mode = 1'b1;
        send_request(CMD_SETUP, 8'd0, 16'd1, 16'd0, 8'd0);
        repeat (OVER_TICKS) send_request(CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        // zero delay lowers the count to the cap
        send_request(CMD_DELAY, 8'd0, 16'd0, 16'd0, 8'd0);
        repeat (20) send_request(CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
        // trigger lowers it too once the slot is aperiodic
        send_request(CMD_SETUP, 8'd0, 16'd0, 16'd0, 8'd0);
        send_request(CMD_TRIG, 8'd0, 16'd0, 16'd0, 8'd0);
        send_request(CMD_DISP, 8'd0, 16'd0, 16'd0, 8'd0);
        burst_mode = 1'b0;
    endtask

    // Random mix with small periods so slots fire, overrun and dispatch often
    task automatic test_random_traffic(input int n);
        logic [CMD_W-1:0]  c;
        logic [TIDX_W-1:0] idx;
        logic [SLOT_W-1:0] per;
        logic [SLOT_W-1:0] st;
        logic [DLY_W-1:0]  dly;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                c = CMD_TICK;
            else if (pick < 50)
                c = CMD_SETUP;
            else if (pick < 63)
                c = CMD_TRIG;
            else if (pick < 78)
                c = CMD_DELAY;
            else if (pick < 97)
                c = CMD_DISP;
            else
                c = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            if ($urandom_range(0, 99) < 88)
                idx = TIDX_W'($urandom_range(0, SLOTS - 1));
            else
                idx = TIDX_W'($urandom_range(SLOTS, 255));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                per = SLOT_W'($urandom_range(1, 8));
            else if (pick < 8)
                per = '0;
            else
                per = SLOT_W'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 9) < 7)
                st = SLOT_W'($urandom_range(0, 10));
            else
                st = SLOT_W'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 9) < 8)
                dly = DLY_W'($urandom_range(0, 10));
            else
                dly = DLY_W'($urandom_range(0, 8'hFF));
            send_request(c, idx, per, st, dly);
        end
    endtask

    initial
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            exp_period[k] = '0;
            exp_timer[k]  = '0;
            exp_count[k]  = '0;
        end
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_TICK;
        task_index <= '0;
        period     <= '0;
        start_time <= '0;
        delay      <= '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_dispatch();
        test_setup_tick();
        test_trigger();
        test_delay();
        test_unused_codes();
        test_pending_over_limit();
        test_random_traffic(RANDOM_ITEMS);

        // drain outstanding results; the watchdog bounds the wait
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> periodic_task_tick_scheduler_top.f
sv/ptts_pkg.sv
sv/ptts_slot_unit.sv
sv/periodic_task_tick_scheduler_top.sv
sv/ptts_checker.sv
tb/sv/tb_periodic_task_tick_scheduler_top.sv
